/* sv/trd_pkg.sv */
// Shared types, codes and helpers for the tape record deframer.
// No dependencies; every other file of the block but trd_stream_if imports this package.
`default_nettype none
package trd_pkg;

   localparam int NAME_BYTES_DEFAULT = 16;
   localparam int FINAL_BIT_DEFAULT  = 31;
   localparam int WORD_BYTES         = 4;

   localparam logic       OP_START = 1'b0;
   localparam logic [1:0] ST_READY = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;

   localparam logic [1:0] RC_OK    = 2'd0;
   localparam logic [1:0] RC_EMPTY = 2'd1;
   localparam logic [1:0] RC_ERROR = 2'd2;

   typedef struct packed {
      logic       operation;
      logic [1:0] drive_status;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic        write_valid;
      logic        in_symbols;
      logic [31:0] write_address;
      logic [7:0]  write_byte;
      logic        load_done;
      logic [1:0]  result_code;
      logic [31:0] start_address;
      logic        final_section;
      logic        release_drive;
      logic [30:0] loaded_length;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_BYTE,
      CMD_FAULT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   code;
      logic [7:0]   data;
   } cmd_type;

   // clear the final-block flag, then clamp to 31 bits
   function automatic logic [30:0] length_of(input logic [31:0] word,
                                             input int unsigned final_bit);
      logic [31:0] cleared;
      cleared = word & ~(32'd1 << final_bit);
      return cleared[31] ? {31{1'b1}} : cleared[30:0];
   endfunction

endpackage
`default_nettype wire

/* sv/trd_stream_if.sv */
// Valid/ready stream interface carrying one payload beat per handshake.
// Payload type is set per instance; used with trd_pkg payload structs.
`default_nettype none
interface trd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* sv/tape_record_deframer.sv */
// Top level of the tape record deframer: front queue plus parser back end.
// Depends on trd_pkg, trd_stream_if, trd_front and trd_back.
//
//   channel   direction  payload            beat
//   req_chan  in         req_payload_type   one drive response or start
//   rsp_chan  out        rsp_payload_type   one result per request beat
//
// One request beat per cycle sustained while the result channel is ready; each result
// passes through a queue slot, then the result register.
// A 2-entry queue parts the two sides; req ready drops only when it is full.
// Synchronous active-high reset empties the queue and returns the parser to idle.
`default_nettype none
module tape_record_deframer #(
   parameter int NAME_BYTES = trd_pkg::NAME_BYTES_DEFAULT,
   parameter int FINAL_BIT  = trd_pkg::FINAL_BIT_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   trd_stream_if.sink    req_chan,
   trd_stream_if.source  rsp_chan
);
   import trd_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;

   trd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   trd_back #(
      .NAME_BYTES (NAME_BYTES),
      .FINAL_BIT  (FINAL_BIT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire

/* sv/trd_front.sv */
// Front end: accepts drive beats, classifies them and queues them.
// Depends on trd_pkg and trd_stream_if.
`default_nettype none
module trd_front (
   input  wire logic          clock,
   input  wire logic          reset,
   trd_stream_if.sink         req_chan,
   output trd_pkg::cmd_type   cmd,
   output logic               cmd_valid,
   input  wire logic          cmd_ready
);
   import trd_pkg::*;

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     classified;
   logic        push, pop;

   always_comb begin
      classified.data = req_chan.payload.data_byte;
      classified.code = RC_OK;
      if (req_chan.payload.operation == OP_START) begin
         classified.kind = CMD_START;
      end else if (req_chan.payload.drive_status == ST_READY) begin
         classified.kind = CMD_BYTE;
      end else begin
         classified.kind = CMD_FAULT;
         classified.code = (req_chan.payload.drive_status == ST_EMPTY) ? RC_EMPTY : RC_ERROR;
      end
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (count_ff != 2'd0);
   assign pop            = cmd_valid && cmd_ready;
   assign cmd            = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* sv/trd_back.sv */
// Back end: record parser state machine and registered result beat.
// Depends on trd_pkg and trd_stream_if.
`default_nettype none
module trd_back #(
   parameter int NAME_BYTES = trd_pkg::NAME_BYTES_DEFAULT,
   parameter int FINAL_BIT  = trd_pkg::FINAL_BIT_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire trd_pkg::cmd_type  cmd,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   trd_stream_if.source           rsp_chan
);
   import trd_pkg::*;

   localparam logic [5:0] NAME_LAST = 6'(NAME_BYTES - 1);
   localparam logic [4:0] WORD_LAST = 5'(WORD_BYTES - 1);

   typedef enum logic [2:0] {
      PH_IDLE, PH_ENTRY, PH_NAME, PH_LOAD, PH_DLEN, PH_DATA, PH_SLEN, PH_SYMS
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [4:0]      index_ff, index_in;
   logic [31:0]     shift_ff, shift_in;
   logic [31:0]     entry_ff, entry_in;
   logic [31:0]     base_ff, base_in;
   logic [30:0]     remain_ff, remain_in;
   logic [30:0]     count_ff, count_in;
   logic            final_ff, final_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            step;

   assign cmd_ready        = !rsp_valid_ff || rsp_chan.ready;
   assign step             = cmd_valid && cmd_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      logic [31:0] shifted;
      logic        word_done;
      logic [30:0] len;
      shifted   = {shift_ff[23:0], cmd.data};
      word_done = (index_ff == WORD_LAST);
      len       = length_of(shifted, FINAL_BIT);

      phase_in  = phase_ff;
      index_in  = index_ff;
      shift_in  = shift_ff;
      entry_in  = entry_ff;
      base_in   = base_ff;
      remain_in = remain_ff;
      count_in  = count_ff;
      final_in  = final_ff;
      rsp_in    = '0;

      unique case (cmd.kind)
         CMD_START: begin
            phase_in  = PH_ENTRY;
            index_in  = '0;
            shift_in  = '0;
            entry_in  = '0;
            base_in   = '0;
            remain_in = '0;
            count_in  = '0;
            final_in  = 1'b0;
         end
         CMD_FAULT: begin
            if (phase_ff != PH_IDLE) begin
               rsp_in.load_done   = 1'b1;
               rsp_in.result_code = cmd.code;
               phase_in           = PH_IDLE;
            end
         end
         default: begin
            unique case (phase_ff) inside
               PH_IDLE: begin
               end
               PH_ENTRY, PH_LOAD, PH_DLEN, PH_SLEN: begin
                  shift_in = shifted;
                  index_in = index_ff + 5'd1;
                  if (word_done) begin
                     index_in = '0;
                     shift_in = '0;
                     unique case (phase_ff)
                        PH_ENTRY: begin
                           entry_in = shifted;
                           phase_in = PH_NAME;
                        end
                        PH_LOAD: begin
                           base_in  = shifted;
                           phase_in = PH_DLEN;
                        end
                        PH_DLEN: begin
                           final_in  = shifted[FINAL_BIT];
                           remain_in = len;
                           phase_in  = (len != '0) ? PH_DATA : PH_SLEN;
                        end
                        default: begin
                           remain_in = len;
                           if (len != '0) begin
                              phase_in = PH_SYMS;
                           end else begin
                              rsp_in.load_done = 1'b1;
                              phase_in         = PH_IDLE;
                           end
                        end
                     endcase
                  end
               end
               PH_NAME: begin
                  index_in = index_ff + 5'd1;
                  if (index_ff == NAME_LAST[4:0]) begin
                     index_in = '0;
                     phase_in = PH_LOAD;
                  end
               end
               PH_DATA: begin
                  rsp_in.write_valid   = 1'b1;
                  rsp_in.write_address = base_ff + {1'b0, count_ff};
                  rsp_in.write_byte    = cmd.data;
                  count_in             = count_ff + 31'd1;
                  remain_in            = remain_ff - 31'd1;
                  if (remain_ff == 31'd1) begin
                     phase_in = PH_SLEN;
                  end
               end
               default: begin
                  rsp_in.write_valid   = 1'b1;
                  rsp_in.in_symbols    = 1'b1;
                  rsp_in.write_address = shift_ff;
                  rsp_in.write_byte    = cmd.data;
                  shift_in             = shift_ff + 32'd1;
                  remain_in            = remain_ff - 31'd1;
                  if (remain_ff == 31'd1) begin
                     rsp_in.load_done = 1'b1;
                     phase_in         = PH_IDLE;
                  end
               end
            endcase
            if (rsp_in.load_done) begin
               rsp_in.start_address = entry_ff;
               rsp_in.release_drive = final_ff;
            end
         end
      endcase

      rsp_in.final_section = final_in;
      rsp_in.loaded_length = count_in;
      rsp_valid_in = step ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         index_ff     <= '0;
         shift_ff     <= '0;
         entry_ff     <= '0;
         base_ff      <= '0;
         remain_ff    <= '0;
         count_ff     <= '0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            phase_ff  <= phase_in;
            index_ff  <= index_in;
            shift_ff  <= shift_in;
            entry_ff  <= entry_in;
            base_ff   <= base_in;
            remain_ff <= remain_in;
            count_ff  <= count_in;
            final_ff  <= final_in;
         end
      end
   end

endmodule
`default_nettype wire

/* sv/trd_checker.sv */
// Port-level checks on the deframer result channel, bound to the top level.
// Depends on trd_pkg and tape_record_deframer.
`default_nettype none
module trd_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire trd_pkg::rsp_payload_type rsp_payload
);
   import trd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.result_code != RC_OK |->
         rsp_payload.load_done && !rsp_payload.write_valid &&
         !rsp_payload.release_drive && rsp_payload.start_address == '0)
      else $error("aborted load carries write, release or entry");

   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.write_valid |->
         !rsp_payload.in_symbols && rsp_payload.write_address == '0 &&
         rsp_payload.write_byte == '0)
      else $error("write fields set without a write");

   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.release_drive |->
         rsp_payload.load_done && rsp_payload.final_section &&
         rsp_payload.result_code == RC_OK)
      else $error("drive release outside a successful final load");

endmodule

bind tape_record_deframer trd_checker u_trd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
`default_nettype wire

/* tb/sv/tb_tape_record_deframer.sv */
`timescale 1ns / 100ps
// Testbench for tape_record_deframer: drives start and drive-response beats,
// predicts every result with its own record parser and checks it field by field.
// Depends on trd_pkg, trd_stream_if and the tape_record_deframer RTL.
module tb_tape_record_deframer;
   import trd_pkg::*;

   localparam int         NAME_LEN      = NAME_BYTES_DEFAULT;
   localparam int         FINAL_POS     = FINAL_BIT_DEFAULT;
   localparam int         HEADER_LEN    = 3 * WORD_BYTES + NAME_LEN;
   localparam logic       OP_RESPONSE   = 1'b1;
   localparam logic [1:0] ST_FAULT      = 2'd2;
   localparam logic [1:0] ST_FAULT_ALT  = 2'd3;
   localparam int         ITEM_TARGET   = 1550;
   localparam int         STALL_LIMIT   = 1000;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         MAX_PRINTS    = 40;

   typedef enum logic [2:0] {
      PARSE_IDLE,
      PARSE_ENTRY,
      PARSE_NAME,
      PARSE_BASE,
      PARSE_DATA_LEN,
      PARSE_DATA,
      PARSE_SYM_LEN,
      PARSE_SYMS
   } parse_phase_type;

   logic clock = 1'b0;
   logic reset;

   trd_stream_if #(.payload_type(req_payload_type)) req_chan ();
   trd_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   tape_record_deframer #(
      .NAME_BYTES(NAME_LEN),
      .FINAL_BIT (FINAL_POS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   parse_phase_type parse_phase;
   logic [4:0]      field_index;
   logic [31:0]     shift_word;
   logic [31:0]     entry_addr;
   logic [31:0]     base_addr;
   logic [30:0]     bytes_left;
   logic [30:0]     data_written;
   logic            final_flag;

   rsp_payload_type expected_results[$];
   int              fail_count    = 0;
   int              results_seen  = 0;
   int              items_sent    = 0;
   int              burst_left    = 0;
   int              gap_max       = 0;
   int              quiet_cycles  = 0;
   int              pattern_age   = 0;
   logic [15:0]     ready_pattern = 16'hFFFF;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void clear_parser();
      parse_phase  = PARSE_IDLE;
      field_index  = '0;
      shift_word   = '0;
      entry_addr   = '0;
      base_addr    = '0;
      bytes_left   = '0;
      data_written = '0;
      final_flag   = 1'b0;
   endfunction

   function automatic logic [30:0] strip_length(input logic [31:0] word);
      logic [31:0] plain;
      plain            = word;
      plain[FINAL_POS] = 1'b0;
      if (plain[31]) begin
         return '1;
      end
      return plain[30:0];
   endfunction

   function automatic logic collect_word_byte(input logic [7:0] b);
      shift_word  = {shift_word[23:0], b};
      field_index = field_index + 5'd1;
      if (field_index >= 5'd4) begin
         field_index = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_payload_type parse_beat(input req_payload_type beat);
      rsp_payload_type res;
      res = '0;
      if (beat.operation == OP_START) begin
         clear_parser();
         parse_phase = PARSE_ENTRY;
      end else if (parse_phase != PARSE_IDLE) begin
         if (beat.drive_status != ST_READY) begin
            res.load_done   = 1'b1;
            res.result_code = (beat.drive_status == ST_EMPTY) ? RC_EMPTY : RC_ERROR;
            parse_phase     = PARSE_IDLE;
         end else begin
            case (parse_phase)
               PARSE_ENTRY: begin
                  if (collect_word_byte(beat.data_byte)) begin
                     entry_addr  = shift_word;
                     shift_word  = '0;
                     parse_phase = PARSE_NAME;
                  end
               end
               PARSE_NAME: begin
                  field_index = field_index + 5'd1;
                  if (field_index >= NAME_LEN) begin
                     field_index = '0;
                     parse_phase = PARSE_BASE;
                  end
               end
               PARSE_BASE: begin
                  if (collect_word_byte(beat.data_byte)) begin
                     base_addr   = shift_word;
                     shift_word  = '0;
                     parse_phase = PARSE_DATA_LEN;
                  end
               end
               PARSE_DATA_LEN: begin
                  if (collect_word_byte(beat.data_byte)) begin
                     final_flag  = shift_word[FINAL_POS];
                     bytes_left  = strip_length(shift_word);
                     shift_word  = '0;
                     parse_phase = (bytes_left != '0) ? PARSE_DATA : PARSE_SYM_LEN;
                  end
               end
               PARSE_DATA: begin
                  res.write_valid   = 1'b1;
                  res.write_address = base_addr + {1'b0, data_written};
                  res.write_byte    = beat.data_byte;
                  data_written      = data_written + 31'd1;
                  bytes_left        = bytes_left - 31'd1;
                  if (bytes_left == '0) begin
                     parse_phase = PARSE_SYM_LEN;
                  end
               end
               PARSE_SYM_LEN: begin
                  if (collect_word_byte(beat.data_byte)) begin
                     bytes_left = strip_length(shift_word);
                     shift_word = '0;
                     if (bytes_left != '0) begin
                        parse_phase = PARSE_SYMS;
                     end else begin
                        res.load_done = 1'b1;
                        parse_phase   = PARSE_IDLE;
                     end
                  end
               end
               PARSE_SYMS: begin
                  res.write_valid   = 1'b1;
                  res.in_symbols    = 1'b1;
                  res.write_address = shift_word;
                  res.write_byte    = beat.data_byte;
                  shift_word        = shift_word + 32'd1;
                  bytes_left        = bytes_left - 31'd1;
                  if (bytes_left == '0) begin
                     res.load_done = 1'b1;
                     parse_phase   = PARSE_IDLE;
                  end
               end
               default: ;
            endcase
            if (res.load_done) begin
               res.start_address = entry_addr;
               res.release_drive = final_flag;
            end
         end
      end
      res.final_section = final_flag;
      res.loaded_length = data_written;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= MAX_PRINTS) begin
         $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
                  $time, results_seen, what, got, want);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         clear_parser();
         expected_results.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(parse_beat(req_chan.payload));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            got = rsp_chan.payload;
            if (expected_results.size() == 0) begin
               report_mismatch("beat with nothing expected", got.write_address, '0);
            end else begin
               want = expected_results.pop_front();
               if (got.write_valid !== want.write_valid)
                  report_mismatch("write_valid", 32'(got.write_valid),
                                  32'(want.write_valid));
               if (got.in_symbols !== want.in_symbols)
                  report_mismatch("in_symbols", 32'(got.in_symbols),
                                  32'(want.in_symbols));
               if (got.write_address !== want.write_address)
                  report_mismatch("write_address", got.write_address, want.write_address);
               if (got.write_byte !== want.write_byte)
                  report_mismatch("write_byte", 32'(got.write_byte),
                                  32'(want.write_byte));
               if (got.load_done !== want.load_done)
                  report_mismatch("load_done", 32'(got.load_done),
                                  32'(want.load_done));
               if (got.result_code !== want.result_code)
                  report_mismatch("result_code", 32'(got.result_code),
                                  32'(want.result_code));
               if (got.start_address !== want.start_address)
                  report_mismatch("start_address", got.start_address, want.start_address);
               if (got.final_section !== want.final_section)
                  report_mismatch("final_section", 32'(got.final_section),
                                  32'(want.final_section));
               if (got.release_drive !== want.release_drive)
                  report_mismatch("release_drive", 32'(got.release_drive),
                                  32'(want.release_drive));
               if (got.loaded_length !== want.loaded_length)
                  report_mismatch("loaded_length", 32'(got.loaded_length),
                                  32'(want.loaded_length));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[tape_record_deframer] ERROR");
         $finish;
      end
   end

   // receiver stalls: rotate a 16-bit pattern, pick a fresh one now and then
   always @(posedge clock) begin
      if (pattern_age == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            ready_pattern = 16'hFFFF;
         end else begin
            ready_pattern = 16'($urandom) | 16'h0101;
         end
      end
      pattern_age      = (pattern_age + 1) % 48;
      rsp_chan.ready  <= ready_pattern[0];
      ready_pattern    = {ready_pattern[0], ready_pattern[15:1]};
   end

   task automatic send_beat(input logic op, input logic [1:0] status, input logic [7:0] b);
      req_payload_type beat;
      beat.operation    = op;
      beat.drive_status = status;
      beat.data_byte    = b;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= beat;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gap_max > 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      if (req_chan.valid) begin
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      while (expected_results.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   function automatic void push_word(ref logic [7:0] tape[$], input logic [31:0] word);
      for (int i = 3; i >= 0; i--) begin
         tape.push_back(word[8 * i +: 8]);
      end
   endfunction

   // send a start and a record; a cut stops after cut_at bytes and sends
   // cut_status instead (ready status means a fresh start)
   task automatic send_record(input logic [31:0] entry, input logic [31:0] base,
                              input logic [31:0] data_word, input logic [31:0] sym_word,
                              input int cut_at, input logic [1:0] cut_status);
      logic [7:0]  tape[$];
      logic [30:0] data_len;
      logic [30:0] sym_len;
      int          limit;
      limit    = (cut_at < 0) ? 32'h7FFF_FFFF : cut_at;
      data_len = strip_length(data_word);
      sym_len  = strip_length(sym_word);
      push_word(tape, entry);
      repeat (NAME_LEN) tape.push_back(8'($urandom));
      push_word(tape, base);
      push_word(tape, data_word);
      for (int i = 0; i < data_len && tape.size() < limit; i++) begin
         tape.push_back(8'($urandom));
      end
      if (tape.size() < limit) begin
         push_word(tape, sym_word);
         for (int i = 0; i < sym_len && tape.size() < limit; i++) begin
            tape.push_back(8'($urandom));
         end
      end
      send_beat(OP_START, 2'($urandom), 8'($urandom));
      foreach (tape[k]) begin
         if (k < limit) begin
            send_beat(OP_RESPONSE, ST_READY, tape[k]);
         end
      end
      if (cut_at >= 0) begin
         if (cut_status == ST_READY) begin
            send_beat(OP_START, 2'($urandom), 8'($urandom));
         end else begin
            send_beat(OP_RESPONSE, cut_status, 8'($urandom));
         end
      end
   endtask

   task automatic test_idle_responses();
      send_beat(OP_RESPONSE, ST_READY, 8'h00);
      send_beat(OP_RESPONSE, ST_EMPTY, 8'hFF);
      send_beat(OP_RESPONSE, ST_FAULT, 8'h5A);
      send_beat(OP_RESPONSE, ST_FAULT_ALT, 8'hA5);
   endtask

   task automatic test_drive_faults();
      send_record($urandom, $urandom, 32'd4, 32'd2, 2, ST_EMPTY);
      send_record($urandom, $urandom, 32'd4, 32'd2, 10, ST_FAULT);
      send_record($urandom, $urandom, 32'd4, 32'd2, 0, ST_FAULT_ALT);
      send_beat(OP_RESPONSE, ST_EMPTY, 8'h00);
   endtask

   task automatic test_restart_mid_load();
      send_record($urandom, $urandom, 32'd2, 32'd1, 25, ST_READY);
   endtask

   task automatic test_empty_sections();
      send_record(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, -1, ST_READY);
   endtask

   task automatic test_final_block_wrap();
      send_record(32'h0000_0000, 32'hFFFF_FFFE, 32'h8000_0003, 32'h8000_0002, -1, ST_READY);
   endtask

   task automatic test_huge_lengths();
      send_record($urandom, $urandom, 32'h7FFF_FFFF, 32'd0, HEADER_LEN + 5, ST_EMPTY);
      send_record($urandom, $urandom, 32'hFFFF_FFFF, 32'd0, HEADER_LEN + 3, ST_FAULT);
   endtask

   task automatic test_random_records();
      logic [31:0] base;
      logic [31:0] data_word;
      logic [31:0] sym_word;
      logic [1:0]  cut_status;
      int          cut_at;
      int          pick;
      int          total;
      int          records;
      records = 0;
      while (items_sent < ITEM_TARGET) begin
         gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) send_beat(OP_RESPONSE, 2'($urandom), 8'($urandom));
         end
         pick      = $urandom_range(0, 19);
         data_word = $urandom_range(0, 12);
         if (pick == 0) begin
            data_word = 32'd0;
         end else if (pick <= 2) begin
            data_word = $urandom_range(13, 48);
         end
         data_word[31] = 1'($urandom);
         sym_word      = $urandom_range(0, 6);
         sym_word[31]  = 1'($urandom);
         base = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom;
         cut_at     = -1;
         cut_status = ST_READY;
         total = HEADER_LEN + WORD_BYTES + int'(strip_length(data_word))
               + int'(strip_length(sym_word));
         if ($urandom_range(0, 3) == 0) begin
            cut_at     = $urandom_range(0, total - 1);
            cut_status = 2'($urandom);
         end
         if (pick == 19) begin
            data_word[30:0] = 31'h7FFF_FF00 | 31'($urandom_range(0, 255));
            cut_at          = $urandom_range(HEADER_LEN, HEADER_LEN + 30);
            cut_status      = 2'($urandom);
         end
         send_record($urandom, base, data_word, sym_word, cut_at, cut_status);
         records++;
         if (records % 8 == 0) begin
            wait_drained();
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_idle_responses();
      test_drive_faults();
      test_restart_mid_load();
      test_empty_sections();
      test_final_block_wrap();
      wait_drained();
      gap_max = 4;
      test_huge_lengths();
      test_random_records();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch("results never arrived", 32'(expected_results.size()), '0);
      end
      if (fail_count == 0) begin
         $display("[tape_record_deframer] OK");
      end else begin
         $display("[tape_record_deframer] ERROR");
      end
      $finish;
   end

endmodule
